[hdl/biou_pkg.sv]
// Shared widths, constants and types for the box overlap ratio block.
// No dependencies; used by biou_div and box_intersection_over_union_top.
`timescale 1ns / 1ps
`default_nettype none

package biou_pkg;

  // Field widths at the ports
  localparam int COORD_W = 16;   // signed corner coordinate, Q.4
  localparam int SIZE_W  = 15;   // unsigned width or height, Q.4
  localparam int RATIO_W = 17;   // unsigned Q1.16 result

  // Internal widths
  localparam int EDGE_W  = COORD_W + 1;     // corner plus size, signed
  localparam int DIFF_W  = EDGE_W + 1;      // overlap extent before clamping
  localparam int AREA_W  = 2 * SIZE_W;      // product of two extents, Q.8
  localparam int UNION_W = AREA_W + 1;      // sum of two areas less overlap
  localparam int FRAC_W  = RATIO_W - 1;     // fraction bits of the result

  // One quotient bit per divider stage
  localparam int DIV_STAGES = RATIO_W;

  // Exactly one in Q1.16
  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRAC_W;

  // Beat handed from the area stages to the divider
  typedef struct packed {
    logic [AREA_W-1:0]  inter;
    logic [UNION_W-1:0] uni;
  } biou_div_req_t;

endpackage

`default_nettype wire

[hdl/biou_div.sv]
// Pipelined restoring divider: floor(inter * 2^16 / uni), one quotient bit per stage.
// Depends on biou_pkg.
`timescale 1ns / 1ps
`default_nettype none

module biou_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  biou_pkg::biou_div_req_t           in_req,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [biou_pkg::RATIO_W-1:0]      out_ratio
);

  localparam int LAST = biou_pkg::DIV_STAGES - 1;

  // Per-stage registers
  logic                             vld_r [0:LAST];
  logic [biou_pkg::UNION_W-1:0]     rem_r [0:LAST];
  logic [biou_pkg::UNION_W-1:0]     dvs_r [0:LAST];
  logic [biou_pkg::RATIO_W-1:0]     quo_r [0:LAST];
  logic                             zer_r [0:LAST];

  logic                             vld_nxt [0:LAST];
  logic [biou_pkg::UNION_W-1:0]     rem_nxt [0:LAST];
  logic [biou_pkg::UNION_W-1:0]     dvs_nxt [0:LAST];
  logic [biou_pkg::RATIO_W-1:0]     quo_nxt [0:LAST];
  logic                             zer_nxt [0:LAST];

  logic                             adv [0:LAST];
  logic [biou_pkg::UNION_W:0]       rsh [0:LAST];
  logic [biou_pkg::UNION_W:0]       dif [0:LAST];
  logic [biou_pkg::UNION_W-1:0]     num0;
  logic                             ge0;

  // Advance chain: a stage loads when it is empty or its successor moves
  always_comb begin
    adv[LAST] = !vld_r[LAST] || !out_stall;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k + 1];
    end
  end

  assign in_stall = !adv[0];

  // First stage: integer quotient bit, overlap never exceeds union
  assign num0 = {1'b0, in_req.inter};
  assign ge0  = num0 >= in_req.uni;

  always_comb begin
    vld_nxt[0] = in_valid;
    dvs_nxt[0] = in_req.uni;
    zer_nxt[0] = (in_req.uni == '0);
    rem_nxt[0] = ge0 ? (num0 - in_req.uni) : num0;
    quo_nxt[0] = {{(biou_pkg::RATIO_W - 1){1'b0}}, ge0};
    rsh[0]     = '0;
    dif[0]     = '0;
    // Fraction stages: shift the remainder, compare, restore
    for (int k = 1; k <= LAST; k++) begin
      rsh[k]     = {rem_r[k - 1], 1'b0};
      dif[k]     = rsh[k] - {1'b0, dvs_r[k - 1]};
      vld_nxt[k] = vld_r[k - 1];
      dvs_nxt[k] = dvs_r[k - 1];
      zer_nxt[k] = zer_r[k - 1];
      if (rsh[k] >= {1'b0, dvs_r[k - 1]}) begin
        rem_nxt[k] = dif[k][biou_pkg::UNION_W-1:0];
        quo_nxt[k] = {quo_r[k - 1][biou_pkg::RATIO_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = rsh[k][biou_pkg::UNION_W-1:0];
        quo_nxt[k] = {quo_r[k - 1][biou_pkg::RATIO_W-2:0], 1'b0};
      end
    end
    // Empty union gives zero
    if (zer_r[LAST - 1]) begin
      quo_nxt[LAST] = '0;
    end
  end

  // Valid bits, cleared by reset
  always_ff @(posedge clk) begin
    for (int k = 0; k <= LAST; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv[k]) begin
        vld_r[k] <= vld_nxt[k];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    for (int k = 0; k <= LAST; k++) begin
      if (adv[k]) begin
        rem_r[k] <= rem_nxt[k];
        dvs_r[k] <= dvs_nxt[k];
        quo_r[k] <= quo_nxt[k];
        zer_r[k] <= zer_nxt[k];
      end
    end
  end

  assign out_valid = vld_r[LAST];
  assign out_ratio = quo_r[LAST];

`ifndef SYNTH
  // An empty union must carry no overlap
  a_zero_union: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && (in_req.uni == '0) |-> in_req.inter == '0)
    else $error("biou_div: empty union with nonzero overlap");

  // Partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAST] && !zer_r[LAST] |-> rem_r[LAST] < dvs_r[LAST])
    else $error("biou_div: remainder not below divisor");

  // Ratio never exceeds one
  a_ratio_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_ratio <= biou_pkg::RATIO_ONE)
    else $error("biou_div: ratio above one");
`endif

endmodule

`default_nettype wire

[hdl/box_intersection_over_union_top.sv]
// Intersection over union of two axis-aligned boxes, Q1.16 result.
// Geometry and area stages here; division in biou_div. Depends on biou_pkg.
//
// Usage:
//   Input channel in_*: one beat carries both boxes (corner x/y signed Q.4,
//   width/height unsigned Q.4). Taken at a clock edge with in_valid high
//   and in_stall low.
//   Output channel out_*: one beat per input beat, out_overlap_ratio is
//   floor(65536 * intersection / union); zero for disjoint or touching
//   boxes and for an empty union. Taken with out_valid high, out_stall low.
//   Pipeline: 4 geometry and area stages, then 17 divider stages, one
//   quotient bit each; a beat's result is registered through them in that
//   order.
//   Throughput: one beat per cycle while out_stall stays low; the 17-stage divider is fully pipelined.
//   Stall: every stage holds while its successor is full and stalled; empty
//   stages keep filling, so input is refused only when all 21 stages hold
//   beats and out_stall is high. Results are never dropped or repeated.
//   Reset: synchronous rst_n clears all valid bits; no other state is kept
//   between beats.
`timescale 1ns / 1ps
`default_nettype none

module box_intersection_over_union_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [biou_pkg::COORD_W-1:0]  in_first_left,
  input  logic signed [biou_pkg::COORD_W-1:0]  in_first_top,
  input  logic        [biou_pkg::SIZE_W-1:0]   in_first_width,
  input  logic        [biou_pkg::SIZE_W-1:0]   in_first_height,
  input  logic signed [biou_pkg::COORD_W-1:0]  in_second_left,
  input  logic signed [biou_pkg::COORD_W-1:0]  in_second_top,
  input  logic        [biou_pkg::SIZE_W-1:0]   in_second_width,
  input  logic        [biou_pkg::SIZE_W-1:0]   in_second_height,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [biou_pkg::RATIO_W-1:0]  out_overlap_ratio
);

  // Stage 1: overlap start and both box ends
  logic                                f1_vld_r;
  logic signed [biou_pkg::COORD_W-1:0] f1_lo_x_r, f1_lo_y_r;
  logic signed [biou_pkg::EDGE_W-1:0]  f1_ae_x_r, f1_be_x_r, f1_ae_y_r, f1_be_y_r;
  logic [biou_pkg::SIZE_W-1:0]         f1_aw_r, f1_ah_r, f1_bw_r, f1_bh_r;

  logic signed [biou_pkg::COORD_W-1:0] f1_lo_x_nxt, f1_lo_y_nxt;
  logic signed [biou_pkg::EDGE_W-1:0]  f1_ae_x_nxt, f1_be_x_nxt, f1_ae_y_nxt, f1_be_y_nxt;

  // Stage 2: clamped overlap extents
  logic                                f2_vld_r;
  logic [biou_pkg::SIZE_W-1:0]         f2_ext_x_r, f2_ext_y_r;
  logic [biou_pkg::SIZE_W-1:0]         f2_aw_r, f2_ah_r, f2_bw_r, f2_bh_r;

  logic signed [biou_pkg::EDGE_W-1:0]  f2_hi_x, f2_hi_y;
  logic signed [biou_pkg::DIFF_W-1:0]  f2_dx, f2_dy;
  logic [biou_pkg::SIZE_W-1:0]         f2_ext_x_nxt, f2_ext_y_nxt;

  // Stage 3: areas
  logic                                f3_vld_r;
  logic [biou_pkg::AREA_W-1:0]         f3_inter_r, f3_area_a_r, f3_area_b_r;

  // Stage 4: union, handed to the divider
  logic                                f4_vld_r;
  biou_pkg::biou_div_req_t             f4_req_r;
  biou_pkg::biou_div_req_t             f4_req_nxt;

  logic adv1, adv2, adv3, adv4;
  logic div_stall;

  // Advance chain through the front stages
  assign adv4     = !f4_vld_r || !div_stall;
  assign adv3     = !f3_vld_r || adv4;
  assign adv2     = !f2_vld_r || adv3;
  assign adv1     = !f1_vld_r || adv2;
  assign in_stall = !adv1;

  // Stage 1 logic: larger start, both ends
  assign f1_lo_x_nxt = (in_first_left > in_second_left) ? in_first_left : in_second_left;
  assign f1_lo_y_nxt = (in_first_top > in_second_top) ? in_first_top : in_second_top;
  assign f1_ae_x_nxt = $signed({in_first_left[biou_pkg::COORD_W-1], in_first_left})
                     + $signed({2'b00, in_first_width});
  assign f1_be_x_nxt = $signed({in_second_left[biou_pkg::COORD_W-1], in_second_left})
                     + $signed({2'b00, in_second_width});
  assign f1_ae_y_nxt = $signed({in_first_top[biou_pkg::COORD_W-1], in_first_top})
                     + $signed({2'b00, in_first_height});
  assign f1_be_y_nxt = $signed({in_second_top[biou_pkg::COORD_W-1], in_second_top})
                     + $signed({2'b00, in_second_height});

  // Stage 2 logic: smaller end, extent, zero when disjoint
  assign f2_hi_x = (f1_ae_x_r < f1_be_x_r) ? f1_ae_x_r : f1_be_x_r;
  assign f2_hi_y = (f1_ae_y_r < f1_be_y_r) ? f1_ae_y_r : f1_be_y_r;
  assign f2_dx   = $signed({f2_hi_x[biou_pkg::EDGE_W-1], f2_hi_x})
                 - $signed({{2{f1_lo_x_r[biou_pkg::COORD_W-1]}}, f1_lo_x_r});
  assign f2_dy   = $signed({f2_hi_y[biou_pkg::EDGE_W-1], f2_hi_y})
                 - $signed({{2{f1_lo_y_r[biou_pkg::COORD_W-1]}}, f1_lo_y_r});
  // A non-negative extent is at most the smaller size, so it fits SIZE_W
  assign f2_ext_x_nxt = f2_dx[biou_pkg::DIFF_W-1] ? '0 : f2_dx[biou_pkg::SIZE_W-1:0];
  assign f2_ext_y_nxt = f2_dy[biou_pkg::DIFF_W-1] ? '0 : f2_dy[biou_pkg::SIZE_W-1:0];

  // Stage 4 logic: union of the two areas
  always_comb begin
    f4_req_nxt.inter = f3_inter_r;
    f4_req_nxt.uni   = {1'b0, f3_area_a_r} + {1'b0, f3_area_b_r} - {1'b0, f3_inter_r};
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
      f3_vld_r <= 1'b0;
      f4_vld_r <= 1'b0;
    end else begin
      if (adv1) f1_vld_r <= in_valid;
      if (adv2) f2_vld_r <= f1_vld_r;
      if (adv3) f3_vld_r <= f2_vld_r;
      if (adv4) f4_vld_r <= f3_vld_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv1) begin
      f1_lo_x_r <= f1_lo_x_nxt;
      f1_lo_y_r <= f1_lo_y_nxt;
      f1_ae_x_r <= f1_ae_x_nxt;
      f1_be_x_r <= f1_be_x_nxt;
      f1_ae_y_r <= f1_ae_y_nxt;
      f1_be_y_r <= f1_be_y_nxt;
      f1_aw_r   <= in_first_width;
      f1_ah_r   <= in_first_height;
      f1_bw_r   <= in_second_width;
      f1_bh_r   <= in_second_height;
    end
    if (adv2) begin
      f2_ext_x_r <= f2_ext_x_nxt;
      f2_ext_y_r <= f2_ext_y_nxt;
      f2_aw_r    <= f1_aw_r;
      f2_ah_r    <= f1_ah_r;
      f2_bw_r    <= f1_bw_r;
      f2_bh_r    <= f1_bh_r;
    end
    // Three independent 15x15 products, operands widened to the area width
    if (adv3) begin
      f3_inter_r  <= {{biou_pkg::SIZE_W{1'b0}}, f2_ext_x_r}
                   * {{biou_pkg::SIZE_W{1'b0}}, f2_ext_y_r};
      f3_area_a_r <= {{biou_pkg::SIZE_W{1'b0}}, f2_aw_r}
                   * {{biou_pkg::SIZE_W{1'b0}}, f2_ah_r};
      f3_area_b_r <= {{biou_pkg::SIZE_W{1'b0}}, f2_bw_r}
                   * {{biou_pkg::SIZE_W{1'b0}}, f2_bh_r};
    end
    if (adv4) begin
      f4_req_r <= f4_req_nxt;
    end
  end

  // Quotient pipeline
  biou_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f4_vld_r),
    .in_stall  (div_stall),
    .in_req    (f4_req_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_ratio (out_overlap_ratio)
  );

`ifndef SYNTH
  // Input is refused only when the output end is blocked
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("box_iou: input stalled without output backpressure");

  // Overlap area never exceeds either box area
  a_inter_a: assert property (@(posedge clk) disable iff (!rst_n)
    f3_vld_r |-> f3_inter_r <= f3_area_a_r)
    else $error("box_iou: overlap larger than first box");

  a_inter_b: assert property (@(posedge clk) disable iff (!rst_n)
    f3_vld_r |-> f3_inter_r <= f3_area_b_r)
    else $error("box_iou: overlap larger than second box");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for box_intersection_over_union_top: directed corner cases,
// random box pairs, full-rate traffic and a long output hold-off. Expected ratios are
// computed in-house from the box geometry. Depends on biou_pkg and the RTL only.
`timescale 1ns / 1ps

module testbench;

  localparam int COORD_W = biou_pkg::COORD_W;
  localparam int SIZE_W  = biou_pkg::SIZE_W;
  localparam int RATIO_W = biou_pkg::RATIO_W;
  localparam int FRAC_W  = biou_pkg::FRAC_W;

  localparam int IDLE_PCT       = 34;    // chance in 100 that a side idles in a cycle
  localparam int HOLD_CYCLES    = 80;    // long receiver hold-off, fills the pipeline
  localparam int DRAIN_CYCLES   = 40;    // extra wait after the last expected result
  localparam int QUIET_LIMIT    = 2000;  // cycles without any accepted beat
  localparam int RANDOM_PAIRS   = 1600;
  localparam int FULL_RATE_ITEMS = 150;
  localparam int PRESSURE_ITEMS = 100;

  // One input beat: both boxes
  typedef struct packed {
    logic signed [COORD_W-1:0] first_left;
    logic signed [COORD_W-1:0] first_top;
    logic        [SIZE_W-1:0]  first_width;
    logic        [SIZE_W-1:0]  first_height;
    logic signed [COORD_W-1:0] second_left;
    logic signed [COORD_W-1:0] second_top;
    logic        [SIZE_W-1:0]  second_width;
    logic        [SIZE_W-1:0]  second_height;
  } box_pair_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] in_first_left = '0;
  logic signed [COORD_W-1:0] in_first_top = '0;
  logic        [SIZE_W-1:0]  in_first_width = '0;
  logic        [SIZE_W-1:0]  in_first_height = '0;
  logic signed [COORD_W-1:0] in_second_left = '0;
  logic signed [COORD_W-1:0] in_second_top = '0;
  logic        [SIZE_W-1:0]  in_second_width = '0;
  logic        [SIZE_W-1:0]  in_second_height = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic        [RATIO_W-1:0] out_overlap_ratio;

  logic [RATIO_W-1:0] expected_ratios[$];
  logic [RATIO_W-1:0] wanted_ratio;
  int in_idle_pct = IDLE_PCT;
  int out_idle_pct = IDLE_PCT;
  int hold_left = 0;
  int pairs_sent = 0;
  int ratios_checked = 0;
  int mismatches = 0;
  int input_stall_cycles = 0;
  int quiet_cycles = 0;

  box_intersection_over_union_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_first_left     (in_first_left),
    .in_first_top      (in_first_top),
    .in_first_width    (in_first_width),
    .in_first_height   (in_first_height),
    .in_second_left    (in_second_left),
    .in_second_top     (in_second_top),
    .in_second_width   (in_second_width),
    .in_second_height  (in_second_height),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_overlap_ratio (out_overlap_ratio)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Intersection over union, exact integer areas, truncated Q1.16 quotient
  function automatic logic [RATIO_W-1:0] overlap_ratio_of(input box_pair_t p);
    longint a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h;
    longint lo_x, lo_y, hi_x, hi_y, inter, joint_area;
    a_x = p.first_left;
    a_y = p.first_top;
    a_w = p.first_width;
    a_h = p.first_height;
    b_x = p.second_left;
    b_y = p.second_top;
    b_w = p.second_width;
    b_h = p.second_height;
    lo_x = (a_x > b_x) ? a_x : b_x;
    lo_y = (a_y > b_y) ? a_y : b_y;
    hi_x = (a_x + a_w < b_x + b_w) ? a_x + a_w : b_x + b_w;
    hi_y = (a_y + a_h < b_y + b_h) ? a_y + a_h : b_y + b_h;
    if (hi_x < lo_x || hi_y < lo_y) return '0;
    inter = (hi_x - lo_x) * (hi_y - lo_y);
    joint_area = a_w * a_h + b_w * b_h - inter;
    if (joint_area == 0) return '0;
    return RATIO_W'((inter << FRAC_W) / joint_area);
  endfunction

  function automatic box_pair_t pack_pair(input int al, at, aw, ah, bl, bt, bw, bh);
    box_pair_t p;
    p.first_left    = COORD_W'(al);
    p.first_top     = COORD_W'(at);
    p.first_width   = SIZE_W'(aw);
    p.first_height  = SIZE_W'(ah);
    p.second_left   = COORD_W'(bl);
    p.second_top    = COORD_W'(bt);
    p.second_width  = SIZE_W'(bw);
    p.second_height = SIZE_W'(bh);
    return p;
  endfunction

  // Mostly small sizes, a quarter anywhere in the full range
  function automatic logic [SIZE_W-1:0] random_size();
    if ($urandom_range(3) == 0) return SIZE_W'($urandom);
    return SIZE_W'($urandom_range(0, 2047));
  endfunction

  function automatic logic [COORD_W-1:0] edge_coord();
    case ($urandom_range(3))
      0: return {1'b1, {(COORD_W-1){1'b0}}};
      1: return {1'b0, {(COORD_W-1){1'b1}}};
      2: return '0;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] edge_size();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return SIZE_W'(1);
      default: return random_size();
    endcase
  endfunction

  // Overlapping pairs mostly; unrelated boxes and extreme values for the rest
  function automatic box_pair_t random_pair();
    box_pair_t p;
    int pick, span;
    pick = $urandom_range(99);
    p.first_left   = COORD_W'($urandom);
    p.first_top    = COORD_W'($urandom);
    p.first_width  = random_size();
    p.first_height = random_size();
    p.second_width  = random_size();
    p.second_height = random_size();
    if (pick < 65) begin
      span = int'(p.first_width) + 16;
      p.second_left = COORD_W'(int'(p.first_left) + int'($urandom_range(0, 2 * span)) - span);
      span = int'(p.first_height) + 16;
      p.second_top = COORD_W'(int'(p.first_top) + int'($urandom_range(0, 2 * span)) - span);
    end else if (pick < 90) begin
      p.second_left = COORD_W'($urandom);
      p.second_top  = COORD_W'($urandom);
    end else begin
      p.first_left    = edge_coord();
      p.first_top     = edge_coord();
      p.first_width   = edge_size();
      p.first_height  = edge_size();
      p.second_left   = edge_coord();
      p.second_top    = edge_coord();
      p.second_width  = edge_size();
      p.second_height = edge_size();
    end
    return p;
  endfunction

  // Send one beat; entered and left at a falling edge, valid stays high between beats unless the sender idles
  task automatic send_pair(input box_pair_t p);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_first_left    <= p.first_left;
    in_first_top     <= p.first_top;
    in_first_width   <= p.first_width;
    in_first_height  <= p.first_height;
    in_second_left   <= p.second_left;
    in_second_top    <= p.second_top;
    in_second_width  <= p.second_width;
    in_second_height <= p.second_height;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_ratios = {expected_ratios, overlap_ratio_of(p)};
    pairs_sent++;
    @(negedge clk);
  endtask

  // Receiver stall: random idling, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_ratios.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with none expected, expected none, actual %0d", $time,
                 out_overlap_ratio);
      end else begin
        wanted_ratio = expected_ratios.pop_front();
        ratios_checked++;
        if (out_overlap_ratio !== wanted_ratio) begin
          mismatches++;
          $display("%0t: overlap_ratio mismatch, expected %0d, actual %0d", $time,
                   wanted_ratio, out_overlap_ratio);
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (in_valid && in_stall) input_stall_cycles <= input_stall_cycles + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Corner cases, Q.4 so 16 is one unit
  task automatic test_directed();
    send_pair(pack_pair(0, 0, 160, 160, 0, 0, 160, 160));          // identical
    send_pair(pack_pair(5, 5, 1, 1, 5, 5, 1, 1));                  // identical, one LSB
    send_pair(pack_pair(0, 0, 16, 16, 32, 0, 16, 16));             // disjoint in x
    send_pair(pack_pair(0, 0, 16, 16, 0, 40, 16, 16));             // disjoint in y
    send_pair(pack_pair(0, 0, 16, 16, 16, 0, 16, 16));             // touching in x
    send_pair(pack_pair(0, 0, 16, 16, 0, 16, 16, 16));             // touching in y
    send_pair(pack_pair(3, 3, 0, 0, 3, 3, 0, 0));                  // empty union
    send_pair(pack_pair(10, 0, 0, 40, 0, 10, 40, 0));              // crossing lines
    send_pair(pack_pair(0, 0, 0, 0, -16, -16, 32, 32));            // point inside box
    send_pair(pack_pair(0, 0, 0, 100, 0, 0, 100, 100));            // zero width on edge
    send_pair(pack_pair(0, 0, 64, 64, 16, 16, 16, 16));            // contained
    send_pair(pack_pair(16, 16, 16, 16, 0, 0, 64, 64));            // container second
    send_pair(pack_pair(0, 0, 32, 16, 16, 0, 32, 16));             // one third
    send_pair(pack_pair(16, 0, 32, 16, 0, 0, 32, 16));             // swapped
    send_pair(pack_pair(-100, -50, 80, 60, -60, -30, 80, 60));     // negative corners
    send_pair(pack_pair(32767, 32767, 32767, 32767,
                        32767, 32767, 32767, 32767));              // widest edges
    send_pair(pack_pair(-32768, -32768, 32767, 32767,
                        32767, 32767, 32767, 32767));              // far apart extremes
    send_pair(pack_pair(-32768, -32768, 32767, 32767,
                        -16384, -16384, 32767, 32767));            // large partial overlap
    send_pair(pack_pair(-32768, -32768, 32767, 32767,
                        -1, -1, 32767, 32767));                    // large, touching corner
    send_pair(pack_pair(0, 0, 32767, 32767, 0, 0, 32767, 32766));  // just under one
    send_pair(pack_pair(0, 0, 32767, 32767, 0, 0, 16384, 16384));  // size top bits
    send_pair(pack_pair(-32768, 32767, 32767, 0, -32768, 32767, 32767, 1));
  endtask

  task automatic test_random_pairs();
    repeat (RANDOM_PAIRS) send_pair(random_pair());
  endtask

  // Long stretch with no idling on either side
  task automatic test_full_rate();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (FULL_RATE_ITEMS) send_pair(random_pair());
    in_idle_pct  = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    in_idle_pct = 0;
    hold_left   = HOLD_CYCLES;
    repeat (PRESSURE_ITEMS) send_pair(random_pair());
    in_idle_pct = IDLE_PCT;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_pairs();
    test_full_rate();
    test_backpressure();

    // Drain: wait for every expected result, then DRAIN_CYCLES more for any stray result
    in_valid <= 1'b0;
    while (expected_ratios.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d box pairs (corner cases, random overlaps, full rate, hold-off);",
             pairs_sent);
    $display("checked %0d ratios, %0d mismatches, input stalled %0d cycles.",
             ratios_checked, mismatches, input_stall_cycles);
    if (mismatches == 0 && expected_ratios.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
